// ===== sv/nrp_pkg.sv =====
`default_nettype none

package nrp_pkg;

	localparam int WORD_W     = 32;
	localparam int DIV_CNT_W  = 6;
	localparam int COLL_W     = 2;
	localparam int ADDR_W     = 3;

	localparam logic [ADDR_W-1:0] REG_SEED = 3'd0;

	localparam logic [WORD_W-1:0] STEP_WEYL     = 32'h9E3779B9;
	localparam logic [WORD_W-1:0] MIX_MUL_A     = 32'h7FEB352D;
	localparam logic [WORD_W-1:0] MIX_MUL_B     = 32'h846CA68B;
	localparam logic [WORD_W-1:0] SEED_ZERO_SUB = 32'h6D2B79F5;

	// Source of the value placed on the result port
	typedef enum logic [1:0] {
		SEL_RECORD,
		SEL_ZERO,
		SEL_DRAWN
	} emit_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      record_write;
		logic      seed;
		logic      cut_start;
		logic      save_cut;
		logic      weyl_step;
		logic      mul1;
		logic      mul2;
		logic      mod_start;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_record;
		logic small_count;
		logic lim_one;
		logic div_busy;
		logic reject;
	} status_t;

endpackage

`default_nettype wire

// ===== sv/nrp_ctrl.sv =====
`default_nettype none

module nrp_ctrl
	import nrp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output cmd_t         cmd,
	output logic         busy
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_CUT,
		S_WEYL,
		S_MUL1,
		S_MUL2,
		S_CHECK,
		S_MOD
	} state_t;

	state_t state_q;
	state_t state_d;

	// Decode commands and next state
	always_comb begin
		cmd      = '0;
		cmd.emit_sel = SEL_ZERO;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.is_record) begin
					cmd.record_write = 1'b1;
					cmd.emit         = 1'b1;
					cmd.emit_sel     = SEL_RECORD;
					state_d          = S_IDLE;
				end else if (status.small_count) begin
					cmd.seed     = 1'b1;
					cmd.emit     = 1'b1;
					cmd.emit_sel = SEL_ZERO;
					state_d      = S_IDLE;
				end else if (status.lim_one) begin
					// One value left after skipping the stored pick: draw no word
					cmd.seed      = 1'b1;
					cmd.cut_start = 1'b1;
					state_d       = S_MOD;
				end else begin
					cmd.seed      = 1'b1;
					cmd.cut_start = 1'b1;
					state_d       = S_CUT;
				end
			end
			S_CUT: begin
				if (!status.div_busy) begin
					cmd.save_cut = 1'b1;
					state_d      = S_WEYL;
				end
			end
			S_WEYL: begin
				cmd.weyl_step = 1'b1;
				state_d       = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (status.reject) begin
					state_d = S_WEYL;
				end else begin
					cmd.mod_start = 1'b1;
					state_d       = S_MOD;
				end
			end
			S_MOD: begin
				if (!status.div_busy) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = SEL_DRAWN;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/nrp_dp.sv =====
`default_nettype none

module nrp_dp
	import nrp_pkg::*;
#(
	parameter int COLLECTIONS = 4,
	parameter int INDEX_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	output status_t                     status,
	input  wire logic [WORD_W-1:0]      seed,
	input  wire logic                   mode,
	input  wire logic [COLL_W-1:0]      collection,
	input  wire logic [INDEX_WIDTH-1:0] item_count,
	input  wire logic [INDEX_WIDTH-1:0] record_index,
	output logic                        done,
	output logic [INDEX_WIDTH-1:0]      picked_index
);

	localparam int PW = INDEX_WIDTH + 1;

	// Request registers
	logic                   mode_q;
	logic [COLL_W-1:0]      coll_q;
	logic [INDEX_WIDTH-1:0] count_q;
	logic [INDEX_WIDTH-1:0] rec_q;
	logic [PW-1:0]          prev_q;

	// Previous picks per collection
	logic [PW-1:0] pick_q [COLLECTIONS];
	logic [PW-1:0] prev_d;

	// Generator
	logic [WORD_W-1:0] weyl_q;
	logic              seeded_q;
	logic [WORD_W-1:0] m1_q;
	logic [WORD_W-1:0] m2_q;
	logic [WORD_W-1:0] mix1_d;
	logic [WORD_W-1:0] mix2_d;
	logic [WORD_W-1:0] word_d;

	// Bounded draw
	logic [INDEX_WIDTH-1:0] lim_q;
	logic [INDEX_WIDTH-1:0] lim_d;
	logic                   excl_q;
	logic                   excl_d;
	logic [WORD_W-1:0]      cut_q;
	logic [WORD_W-1:0]      rem_q;
	logic [WORD_W-1:0]      div_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic [WORD_W:0]        trial;
	logic                   trial_ge;
	logic [INDEX_WIDTH-1:0] drawn;
	logic                   bump;

	// Look up the stored pick of the requested collection
	always_comb begin
		prev_d = '1;
		for (int i = 0; i < COLLECTIONS; i++) begin
			if (int'(collection) == i) begin
				prev_d = pick_q[i];
			end
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			coll_q  <= collection;
			count_q <= item_count;
			rec_q   <= record_index;
			prev_q  <= prev_d;
		end
	end

	// Store a recorded pick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COLLECTIONS; i++) begin
				pick_q[i] <= '1;
			end
		end else if (cmd.record_write) begin
			for (int i = 0; i < COLLECTIONS; i++) begin
				if (int'(coll_q) == i) begin
					pick_q[i] <= {1'b0, rec_q};
				end
			end
		end
	end

	// Seed once, then advance the Weyl state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weyl_q   <= '0;
			seeded_q <= 1'b0;
		end else if (cmd.seed && !seeded_q) begin
			weyl_q   <= (seed == '0) ? SEED_ZERO_SUB : seed;
			seeded_q <= 1'b1;
		end else if (cmd.weyl_step) begin
			weyl_q <= weyl_q + STEP_WEYL;
		end
	end

	// Avalanche mixer, one multiply per stage
	assign mix1_d = weyl_q ^ (weyl_q >> 16);
	assign mix2_d = m1_q ^ (m1_q >> 15);
	assign word_d = m2_q ^ (m2_q >> 16);

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			m1_q <= mix1_d * MIX_MUL_A;
		end
		if (cmd.mul2) begin
			m2_q <= mix2_d * MIX_MUL_B;
		end
	end

	// Bound: skip the previous pick when it lies below the count
	assign excl_d = (prev_q < {1'b0, count_q});
	assign lim_d  = excl_d ? (count_q - INDEX_WIDTH'(1)) : count_q;

	// Restoring remainder, one bit per cycle
	assign trial    = {rem_q, div_q[WORD_W-1]};
	assign trial_ge = (trial >= (WORD_W+1)'(lim_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cut_start || cmd.mod_start) begin
			cnt_q <= DIV_CNT_W'(WORD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cut_start) begin
			lim_q  <= lim_d;
			excl_q <= excl_d;
			rem_q  <= '0;
			div_q  <= WORD_W'(0) - WORD_W'(lim_d);
		end else if (cmd.mod_start) begin
			rem_q <= '0;
			div_q <= word_d;
		end else if (cnt_q != '0) begin
			rem_q <= trial_ge ? WORD_W'(trial - (WORD_W+1)'(lim_q)) : trial[WORD_W-1:0];
			div_q <= {div_q[WORD_W-2:0], 1'b0};
		end
		if (cmd.save_cut) begin
			cut_q <= rem_q;
		end
	end

	// Raise the drawn value past the excluded pick
	assign drawn = rem_q[INDEX_WIDTH-1:0];
	assign bump  = excl_q && ({1'b0, drawn} >= prev_q);

	// Result register and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_sel)
				SEL_RECORD: picked_index <= rec_q;
				SEL_DRAWN:  picked_index <= drawn + INDEX_WIDTH'(bump);
				default:    picked_index <= '0;
			endcase
		end
	end

	assign status.is_record   = mode_q;
	assign status.small_count = (count_q <= INDEX_WIDTH'(1));
	assign status.lim_one     = (lim_d == INDEX_WIDTH'(1));
	assign status.div_busy    = (cnt_q != '0);
	assign status.reject      = (word_d < cut_q);

endmodule

`default_nettype wire

// ===== sv/no_repeat_random_index_picker.sv =====
// A record request or a count of 0 or 1 raises the result strobe straight from the decide state.
// A draw runs the cut remainder, then the Weyl, two multiply and check states for each generated
// word, redrawing any rejected word, then the final remainder; a count of 2 with its stored pick
// excluded draws no word. The remainder unit works one bit per cycle.
// One request at a time; busy is high until the strobe, so the next start is taken at the edge
// that ends the strobe. Results cannot be stalled. Reset clears generator, flag and picks.
`default_nettype none

module no_repeat_random_index_picker
	import nrp_pkg::*;
#(
	parameter int COLLECTIONS = 4,
	parameter int INDEX_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [WORD_W-1:0]      pwdata,
	output logic [WORD_W-1:0]           prdata,
	output logic                        pready,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   mode,
	input  wire logic [COLL_W-1:0]      collection,
	input  wire logic [INDEX_WIDTH-1:0] item_count,
	input  wire logic [INDEX_WIDTH-1:0] record_index,
	output logic                        done,
	output logic [INDEX_WIDTH-1:0]      picked_index
);

	logic [WORD_W-1:0] seed_q;
	cmd_t              cmd;
	status_t           status;
	logic              ctrl_busy;

	// Seed register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_ZERO_SUB;
		end else if (psel && penable && pwrite && (paddr == REG_SEED)) begin
			seed_q <= pwdata;
		end
	end

	// Register read
	always_comb begin
		unique case (paddr)
			REG_SEED: prdata = seed_q;
			default:  prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	nrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	nrp_dp #(
		.COLLECTIONS (COLLECTIONS),
		.INDEX_WIDTH (INDEX_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.seed         (seed_q),
		.mode         (mode),
		.collection   (collection),
		.item_count   (item_count),
		.record_index (record_index),
		.done         (done),
		.picked_index (picked_index)
	);

	assign busy = ctrl_busy;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
	import nrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = 16;
	localparam int NCOLL = 4;
	localparam bit MODE_DRAW = 1'b0;
	localparam bit MODE_RECORD = 1'b1;
	localparam logic [IDX_W:0] NO_PICK = '1;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 420;

	// Tracks generator state, stored picks and the indices still owed by the block
	class pick_tracker;
		bit [WORD_W-1:0] seed_reg;
		bit [WORD_W-1:0] weyl;
		bit seeded;
		bit [IDX_W:0] last_pick[NCOLL];
		bit [IDX_W-1:0] expected_picks[$];
		int errors;

		function new();
			seed_reg = SEED_ZERO_SUB;
			weyl = '0;
			seeded = 1'b0;
			foreach (last_pick[i]) last_pick[i] = NO_PICK;
			errors = 0;
		endfunction

		function void set_seed(bit [WORD_W-1:0] v);
			seed_reg = v;
		endfunction

		function int pending();
			return expected_picks.size();
		endfunction

		// Advance the Weyl walk and scramble it with the two-multiply mixer
		function bit [WORD_W-1:0] next_word();
			bit [WORD_W-1:0] v;
			weyl = weyl + STEP_WEYL;
			v = weyl;
			v = v ^ (v >> 16);
			v = v * MIX_MUL_A;
			v = v ^ (v >> 15);
			v = v * MIX_MUL_B;
			v = v ^ (v >> 16);
			return v;
		endfunction

		// Unbiased value below lim: drop words under 2^32 mod lim
		function bit [WORD_W-1:0] uniform_below(bit [WORD_W-1:0] lim);
			bit [WORD_W-1:0] cut;
			bit [WORD_W-1:0] w;
			if (lim <= 1) begin
				return '0;
			end
			cut = (32'd0 - lim) % lim;
			do begin
				w = next_word();
			end while (w < cut);
			return w % lim;
		endfunction

		function bit [IDX_W-1:0] note_request(bit m, bit [COLL_W-1:0] c,
				bit [IDX_W-1:0] cnt, bit [IDX_W-1:0] rec);
			bit [WORD_W-1:0] idx;
			bit [IDX_W:0] prev;
			if (m == MODE_RECORD) begin
				last_pick[c] = {1'b0, rec};
				expected_picks.push_back(rec);
				return rec;
			end
			// First draw latches the seed, zero maps to the substitute constant
			if (!seeded) begin
				weyl = (seed_reg == '0) ? SEED_ZERO_SUB : seed_reg;
				seeded = 1'b1;
			end
			if (cnt <= 1) begin
				idx = '0;
			end else begin
				prev = last_pick[c];
				if (prev >= cnt) begin
					idx = uniform_below(32'(cnt));
				end else begin
					// Skip over the previous pick
					idx = uniform_below(32'(cnt) - 32'd1);
					if (idx >= 32'(prev)) idx = idx + 1;
				end
			end
			expected_picks.push_back(idx[IDX_W-1:0]);
			return idx[IDX_W-1:0];
		endfunction

		function void check_pick(bit [IDX_W-1:0] got);
			bit [IDX_W-1:0] want;
			if (expected_picks.size() == 0) begin
				$display("%0t: picked_index expected none, actual %0d", $time, got);
				errors++;
				return;
			end
			want = expected_picks.pop_front();
			if (got !== want) begin
				$display("%0t: picked_index expected %0d, actual %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [WORD_W-1:0] pwdata;
	logic [WORD_W-1:0] prdata;
	logic pready;
	logic start, busy;
	logic mode;
	logic [COLL_W-1:0] collection;
	logic [IDX_W-1:0] item_count, record_index;
	logic done;
	logic [IDX_W-1:0] picked_index;

	pick_tracker sb;
	int items_sent;
	bit calm;

	no_repeat_random_index_picker #(
		.COLLECTIONS(NCOLL),
		.INDEX_WIDTH(IDX_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.mode(mode),
		.collection(collection),
		.item_count(item_count),
		.record_index(record_index),
		.done(done),
		.picked_index(picked_index)
	);

	always #10 clk = ~clk;

	// Check every result transfer against the oldest owed index
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) sb.check_pick(picked_index);
	end

	// End the run if no transfer happens for too long
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) stall_cycles = 0;
			else stall_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Write the seed register, then read it back
	task automatic write_seed(bit [WORD_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SEED;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_seed(v);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== v) begin
			$display("%0t: seed readback expected %h, actual %h", $time, v, prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Present one request and hold it until the block takes it; start stays high
	task automatic send(bit m, bit [COLL_W-1:0] c, bit [IDX_W-1:0] cnt,
			bit [IDX_W-1:0] rec, output bit [IDX_W-1:0] want);
		start <= 1'b1;
		mode <= m;
		collection <= c;
		item_count <= cnt;
		record_index <= rec;
		do @(posedge clk); while (busy !== 1'b0);
		want = sb.note_request(m, c, cnt, rec);
		items_sent++;
	endtask

	// Occasionally drop start for a random gap
	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
		end
	endtask

	task automatic issue(bit m, bit [COLL_W-1:0] c, bit [IDX_W-1:0] cnt,
			bit [IDX_W-1:0] rec);
		bit [IDX_W-1:0] want;
		send(m, c, cnt, rec, want);
		maybe_idle();
	endtask

	// Hold off the sender until the block has answered everything
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	function automatic bit [IDX_W-1:0] rand_count();
		int r;
		r = $urandom_range(99);
		if (r < 10) return IDX_W'($urandom_range(0, 1));
		if (r < 70) return IDX_W'($urandom_range(2, 16));
		if (r < 85) return IDX_W'($urandom_range(17, 1024));
		return IDX_W'($urandom_range(0, 65535));
	endfunction

	initial begin
		bit [IDX_W-1:0] want;
		bit [COLL_W-1:0] c;
		bit [WORD_W-1:0] first_seed;
		int kind;
		sb = new();
		items_sent = 0;
		calm = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		start <= 1'b0;
		mode <= MODE_DRAW;
		collection <= '0;
		item_count <= '0;
		record_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed that takes effect: zero, all ones or random
		case ($urandom_range(2))
			0: first_seed = '0;
			1: first_seed = '1;
			default: first_seed = $urandom;
		endcase
		write_seed(first_seed);
		@(posedge clk);

		// Directed: record before seeding, small counts, stale and excluded picks, extremes
		issue(MODE_RECORD, 2'd1, 16'h0000, 16'd3);
		issue(MODE_DRAW, 2'd0, 16'd0, 16'hFFFF);
		issue(MODE_DRAW, 2'd0, 16'd1, 16'h0000);
		issue(MODE_DRAW, 2'd1, 16'd8, 16'h0000);
		issue(MODE_DRAW, 2'd1, 16'd3, 16'h0000);
		issue(MODE_DRAW, 2'd1, 16'd2, 16'h0000);
		issue(MODE_DRAW, 2'd2, 16'hFFFF, 16'h0000);
		issue(MODE_RECORD, 2'd2, 16'hFFFF, 16'hFFFF);
		issue(MODE_DRAW, 2'd2, 16'hFFFF, 16'h0000);
		issue(MODE_RECORD, 2'd2, 16'h0000, 16'hFFFE);
		issue(MODE_DRAW, 2'd2, 16'hFFFF, 16'h0000);
		issue(MODE_RECORD, 2'd3, 16'hFFFF, 16'd0);
		issue(MODE_DRAW, 2'd3, 16'd2, 16'hFFFF);
		issue(MODE_RECORD, 2'd3, 16'h0000, 16'd1);
		issue(MODE_DRAW, 2'd3, 16'd2, 16'h0000);
		issue(MODE_RECORD, 2'd0, 16'h5555, 16'hAAAA);
		issue(MODE_DRAW, 2'd0, 16'hAAAB, 16'h5555);
		issue(MODE_DRAW, 2'd0, 16'h8000, 16'hFFFF);
		issue(MODE_DRAW, 2'd3, 16'h7FFF, 16'h0001);

		// Late seed writes must not disturb the running generator
		drain();
		write_seed('0);
		@(posedge clk);

		// Random: mostly draw-then-commit sequences, plus loose draws and records
		while (items_sent < ITEM_TARGET) begin
			calm = (items_sent >= 230 && items_sent < 310);
			if (items_sent >= 200 && items_sent < 204) begin
				drain();
				write_seed('1);
				@(posedge clk);
				write_seed($urandom);
				@(posedge clk);
			end
			c = COLL_W'($urandom_range(NCOLL - 1));
			kind = $urandom_range(99);
			if (kind < 55) begin
				send(MODE_DRAW, c, rand_count(), IDX_W'($urandom), want);
				maybe_idle();
				if ($urandom_range(99) < 85) issue(MODE_RECORD, c, IDX_W'($urandom), want);
				else issue(MODE_RECORD, c, IDX_W'($urandom), IDX_W'($urandom));
			end else if (kind < 75) begin
				issue(MODE_DRAW, c, IDX_W'($urandom), IDX_W'($urandom));
			end else if (kind < 90) begin
				issue(MODE_RECORD, c, IDX_W'($urandom), IDX_W'($urandom));
			end else begin
				issue(MODE_DRAW, c, IDX_W'($urandom_range(0, 2)), IDX_W'($urandom));
			end
		end

		// Let the last results arrive, then a short tail
		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
sv/nrp_pkg.sv
sv/nrp_ctrl.sv
sv/nrp_dp.sv
sv/no_repeat_random_index_picker.sv
tb/testbench.sv
